// ===== hdl/bbrcmc_pkg.sv =====
// Shared types, register map and constants of the BBR mode controller.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package bbrcmc_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned GainW    = 16;
  localparam int unsigned BwW      = 32;
  localparam int unsigned BytesW   = 32;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned StallW   = 2;

  typedef logic [ModeW-1:0] mode_t;

  localparam mode_t MODE_STARTUP   = 2'd0;
  localparam mode_t MODE_DRAIN     = 2'd1;
  localparam mode_t MODE_PROBE_BW  = 2'd2;
  localparam mode_t MODE_PROBE_RTT = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_STARTUP_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DRAIN_GAIN       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GROWTH_THRESHOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STEADY_GAIN      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PROBE_INCREMENT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRAIN_DECREMENT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_NO_PACING_MODE   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MIN_CWND_BYTES   = 3'd7;

  localparam logic [GainW-1:0]  STARTUP_GAIN_RST     = 16'd740;
  localparam logic [GainW-1:0]  DRAIN_GAIN_RST       = 16'd89;
  localparam logic [GainW-1:0]  GROWTH_THRESHOLD_RST = 16'd320;
  localparam logic [GainW-1:0]  STEADY_GAIN_RST      = 16'd256;
  localparam logic [GainW-1:0]  PROBE_INCREMENT_RST  = 16'd64;
  localparam logic [GainW-1:0]  DRAIN_DECREMENT_RST  = 16'd64;
  localparam logic [BytesW-1:0] MIN_CWND_BYTES_RST   = 32'd6000;

  localparam logic [PhaseW-1:0] PHASE_HIGH = 3'd0;
  localparam logic [PhaseW-1:0] PHASE_LOW  = 3'd1;

  localparam logic [StallW-1:0] STALL_EXIT       = 2'd3;
  localparam logic [PhaseW-1:0] DRAIN_ROUNDS_MAX = 3'd5;

  // Q16.16 megabits to bytes: times 10^6/8, then drop 16 fraction bits
  localparam logic [16:0]      DRAIN_BYTES_SCALE = 17'd125000;
  localparam logic [TimeW-1:0] PROBE_RTT_MIN_NS  = 48'd200000000;

  typedef struct packed {
    logic [GainW-1:0]  start_gain;
    logic [GainW-1:0]  drain_gain;
    logic [GainW-1:0]  growth_threshold;
    logic [GainW-1:0]  steady_gain;
    logic [GainW-1:0]  probe_increment;
    logic [GainW-1:0]  drain_decrement;
    logic              no_pacing_mode;
    logic [BytesW-1:0] min_cwnd_bytes;
  } cfg_t;

  typedef struct packed {
    logic              bw_valid;
    logic [BwW-1:0]    bw_estimate;
    logic [BwW-1:0]    bdp_mbit;
    logic [TimeW-1:0]  rtt_ns;
    logic [TimeW-1:0]  now_ns;
    logic [BytesW-1:0] inflight_bytes;
    logic              probe_rtt_due;
    logic [PhaseW-1:0] random_phase;
  } in_item_t;

  typedef struct packed {
    mode_t             mode;
    logic [GainW-1:0]  pacing_gain;
    logic [GainW-1:0]  cwnd_gain;
    logic              force_min_cwnd;
    logic [PhaseW-1:0] gain_phase;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/bbrcmc_if.sv =====
// Valid/ready channels for round-update events and mode results.
// Depends on bbrcmc_pkg for the payload types.
`default_nettype none

interface bbrcmc_in_if;
  import bbrcmc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbrcmc_out_if;
  import bbrcmc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bbrcmc_cfg_regs.sv =====
// Configuration register file of the BBR mode controller.
// Depends on bbrcmc_pkg for the register map and reset values.
`default_nettype none

module bbrcmc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [bbrcmc_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [bbrcmc_pkg::CfgDataW-1:0]  data_i,
  output bbrcmc_pkg::cfg_t                 cfg_o
);
  import bbrcmc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_STARTUP_GAIN:     cfg_d.start_gain       = data_i[GainW-1:0];
        REG_DRAIN_GAIN:       cfg_d.drain_gain       = data_i[GainW-1:0];
        REG_GROWTH_THRESHOLD: cfg_d.growth_threshold = data_i[GainW-1:0];
        REG_STEADY_GAIN:      cfg_d.steady_gain      = data_i[GainW-1:0];
        REG_PROBE_INCREMENT:  cfg_d.probe_increment  = data_i[GainW-1:0];
        REG_DRAIN_DECREMENT:  cfg_d.drain_decrement  = data_i[GainW-1:0];
        REG_NO_PACING_MODE:   cfg_d.no_pacing_mode   = data_i[0];
        REG_MIN_CWND_BYTES:   cfg_d.min_cwnd_bytes   = data_i[BytesW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_gain       <= STARTUP_GAIN_RST;
      cfg_q.drain_gain       <= DRAIN_GAIN_RST;
      cfg_q.growth_threshold <= GROWTH_THRESHOLD_RST;
      cfg_q.steady_gain      <= STEADY_GAIN_RST;
      cfg_q.probe_increment  <= PROBE_INCREMENT_RST;
      cfg_q.drain_decrement  <= DRAIN_DECREMENT_RST;
      cfg_q.no_pacing_mode   <= 1'b0;
      cfg_q.min_cwnd_bytes   <= MIN_CWND_BYTES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/bbrcmc_mode_core.sv =====
// Mode state and one-pass round update of the BBR mode controller.
// Depends on bbrcmc_pkg; driven from the input stage of the top level.
`default_nettype none

module bbrcmc_mode_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bbrcmc_pkg::cfg_t      cfg_i,
  input  bbrcmc_pkg::in_item_t  item_i,
  input  logic                  step_i,
  output bbrcmc_pkg::out_item_t result_o
);
  import bbrcmc_pkg::*;

  mode_t             mode_q, mode_d;
  logic [BwW-1:0]    full_bw_q, full_bw_d;
  logic [StallW-1:0] stall_q, stall_d;
  logic [BytesW-1:0] limit_q, limit_d;
  logic [PhaseW-1:0] drain_rounds_q, drain_rounds_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimeW-1:0]  rtt_end_q, rtt_end_d;
  logic [GainW-1:0]  pacing_q, pacing_d;
  logic [GainW-1:0]  cwnd_q, cwnd_d;
  logic              force_min;

  logic [BwW+7:0]       grow_lhs;
  logic [BwW+GainW-1:0] grow_rhs;
  logic [BwW+16:0]      drain_prod;
  logic [BytesW-1:0]    drain_bytes;
  logic [TimeW-1:0]     hold_ns;
  logic [TimeW:0]       end_sum;
  logic [TimeW-1:0]     end_sat;
  logic [PhaseW-1:0]    entry_phase;
  logic [GainW:0]       high_sum;
  logic [GainW-1:0]     gain_high;
  logic [GainW-1:0]     low_dec;
  logic [GainW-1:0]     gain_low;
  logic [GainW-1:0]     gain_double;
  logic [GainW-1:0]     entry_pacing;
  logic [GainW-1:0]     cycle_pacing;
  logic [StallW-1:0]    stall_inc;
  logic [PhaseW-1:0]    drain_rounds_inc;

  always_comb begin
    grow_lhs    = {item_i.bw_estimate, 8'd0};
    grow_rhs    = full_bw_q * cfg_i.growth_threshold;
    drain_prod  = item_i.bdp_mbit * DRAIN_BYTES_SCALE;
    drain_bytes = drain_prod[BwW+16] ? {BytesW{1'b1}} : drain_prod[BwW+15:16];

    hold_ns = (item_i.rtt_ns > PROBE_RTT_MIN_NS) ? item_i.rtt_ns : PROBE_RTT_MIN_NS;
    end_sum = {1'b0, item_i.now_ns} + {1'b0, hold_ns};
    end_sat = end_sum[TimeW] ? {TimeW{1'b1}} : end_sum[TimeW-1:0];

    high_sum    = {1'b0, cfg_i.steady_gain} + {1'b0, cfg_i.probe_increment};
    gain_high   = high_sum[GainW] ? {GainW{1'b1}} : high_sum[GainW-1:0];
    low_dec     = cfg_i.no_pacing_mode ? {3'd0, cfg_i.drain_decrement[GainW-1:3]}
                                       : cfg_i.drain_decrement;
    gain_low    = (cfg_i.steady_gain > low_dec) ? (cfg_i.steady_gain - low_dec) : '0;
    gain_double = cfg_i.steady_gain[GainW-1] ? {GainW{1'b1}}
                                             : {cfg_i.steady_gain[GainW-2:0], 1'b0};

    entry_phase  = (item_i.random_phase == PHASE_LOW) ? 3'd2 : item_i.random_phase;
    entry_pacing = (entry_phase == PHASE_HIGH) ? gain_high : cfg_i.steady_gain;

    unique case (phase_q)
      PHASE_HIGH: cycle_pacing = gain_high;
      PHASE_LOW:  cycle_pacing = gain_low;
      default:    cycle_pacing = cfg_i.steady_gain;
    endcase

    stall_inc        = (stall_q == STALL_EXIT) ? stall_q : stall_q + 2'd1;
    drain_rounds_inc = drain_rounds_q + 3'd1;
  end

  always_comb begin
    mode_d         = mode_q;
    full_bw_d      = full_bw_q;
    stall_d        = stall_q;
    limit_d        = limit_q;
    drain_rounds_d = drain_rounds_q;
    phase_d        = phase_q;
    rtt_end_d      = rtt_end_q;
    pacing_d       = pacing_q;
    cwnd_d         = cwnd_q;
    force_min      = 1'b0;

    if (item_i.probe_rtt_due) begin
      // the fresh end time is never behind now, so no exit in this round
      mode_d    = MODE_PROBE_RTT;
      pacing_d  = cfg_i.steady_gain;
      cwnd_d    = cfg_i.steady_gain;
      rtt_end_d = end_sat;
      force_min = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_STARTUP: begin
          if (item_i.bw_valid) begin
            if ({8'd0, grow_lhs} > grow_rhs) begin
              full_bw_d = item_i.bw_estimate;
              stall_d   = '0;
            end else begin
              stall_d = stall_inc;
              if (stall_inc == STALL_EXIT) begin
                mode_d         = MODE_DRAIN;
                pacing_d       = cfg_i.drain_gain;
                cwnd_d         = cfg_i.no_pacing_mode ? cfg_i.drain_gain
                                                      : cfg_i.start_gain;
                limit_d        = drain_bytes;
                drain_rounds_d = '0;
              end
            end
          end
        end
        MODE_DRAIN: begin
          drain_rounds_d = drain_rounds_inc;
          if (item_i.inflight_bytes < limit_q ||
              drain_rounds_inc == DRAIN_ROUNDS_MAX) begin
            mode_d   = MODE_PROBE_BW;
            phase_d  = entry_phase;
            pacing_d = entry_pacing;
            cwnd_d   = cfg_i.no_pacing_mode ? entry_pacing : gain_double;
          end
        end
        MODE_PROBE_BW: begin
          pacing_d = cycle_pacing;
          cwnd_d   = cfg_i.no_pacing_mode ? cycle_pacing : gain_double;
          phase_d  = phase_q + 3'd1;
        end
        MODE_PROBE_RTT: begin
          force_min = 1'b1;
          if (item_i.now_ns > rtt_end_q) begin
            mode_d   = MODE_PROBE_BW;
            phase_d  = entry_phase;
            pacing_d = entry_pacing;
            cwnd_d   = cfg_i.no_pacing_mode ? entry_pacing : gain_double;
          end
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_STARTUP;
      full_bw_q      <= '0;
      stall_q        <= '0;
      limit_q        <= '0;
      drain_rounds_q <= '0;
      phase_q        <= '0;
      rtt_end_q      <= '0;
      pacing_q       <= STARTUP_GAIN_RST;
      cwnd_q         <= STARTUP_GAIN_RST;
    end else if (step_i) begin
      mode_q         <= mode_d;
      full_bw_q      <= full_bw_d;
      stall_q        <= stall_d;
      limit_q        <= limit_d;
      drain_rounds_q <= drain_rounds_d;
      phase_q        <= phase_d;
      rtt_end_q      <= rtt_end_d;
      pacing_q       <= pacing_d;
      cwnd_q         <= cwnd_d;
    end
  end

  always_comb begin
    result_o.mode           = mode_d;
    result_o.pacing_gain    = pacing_d;
    result_o.cwnd_gain      = cwnd_d;
    result_o.force_min_cwnd = force_min;
    result_o.gain_phase     = phase_d;
  end

endmodule

`default_nettype wire

// ===== hdl/bbr_congestion_mode_control.sv =====
// BBR congestion mode controller: one mode/gain result per round-update event.
// Path: each event passes the input register, then the mode update, then the result register.
// Throughput: one event per cycle unless out_ch stalls; the mode update is a single pass.
// Reset: mode STARTUP, counters and limits zero, gains and config at their defaults.
// Depends on bbrcmc_pkg, bbrcmc_if, bbrcmc_cfg_regs and bbrcmc_mode_core.
`default_nettype none

module bbr_congestion_mode_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bbrcmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bbrcmc_pkg::CfgDataW-1:0] cfg_data_i,
  bbrcmc_in_if.sink                       in_ch,
  bbrcmc_out_if.source                    out_ch
);
  import bbrcmc_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t core_result;
  out_item_t out_item_q;
  logic      out_valid_q;
  logic      s2_free;
  logic      s1_adv;
  logic      in_fire;

  bbrcmc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  bbrcmc_mode_core u_mode_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (s1_item_q),
    .step_i   (s1_adv),
    .result_o (core_result)
  );

  assign s2_free     = !out_valid_q || out_ch.ready;
  assign s1_adv      = s1_valid_q && s2_free;
  assign in_ch.ready = !s1_valid_q || s2_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_fire || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_ch.data;
    end
    if (s1_adv) begin
      out_item_q <= core_result;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_item_q;

  a_force_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.force_min_cwnd |->
      out_item_q.mode == MODE_PROBE_RTT || out_item_q.mode == MODE_PROBE_BW)
    else $error("force_min_cwnd outside probe modes");

  a_rtt_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.mode == MODE_PROBE_RTT |-> out_item_q.force_min_cwnd)
    else $error("probe RTT result without force_min_cwnd");

  a_startup_gains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.mode == MODE_STARTUP |->
      out_item_q.pacing_gain == out_item_q.cwnd_gain)
    else $error("startup gains differ");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(s1_item_q))
    else $error("input stage lost a stalled event");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for bbr_congestion_mode_control: drives round-update events
// through valid/ready channels and checks every mode/gain result against an in-bench model.
// Depends on bbrcmc_pkg, bbrcmc_if and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbrcmc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 23;
  localparam logic [PhaseW-1:0] PhaseLowStart = 3'd2;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bbrcmc_in_if  in_ch ();
  bbrcmc_out_if out_ch ();

  bbr_congestion_mode_control uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  cfg_t              shadow_cfg;
  mode_t             cur_mode;
  logic [BwW-1:0]    full_bw;
  logic [StallW-1:0] stall_cnt;
  logic [BytesW-1:0] drain_limit;
  logic [PhaseW-1:0] drain_cnt;
  logic [PhaseW-1:0] gain_phase;
  logic [TimeW-1:0]  rtt_end;
  logic [GainW-1:0]  pace_gain;
  logic [GainW-1:0]  cwnd_gain;

  out_item_t   pending_results[$];
  out_item_t   oldest;
  int unsigned fail_count;
  int unsigned accepted_count;
  int unsigned probe_rtt_count;
  int unsigned settings_count;
  int unsigned cycle_count;
  logic        no_idle;
  logic [TimeW-1:0] wall_ns;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  task automatic check_field(input string name, input logic [GainW-1:0] want,
                             input logic [GainW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending event: mode %0d", out_ch.data.mode);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (oldest.force_min_cwnd) probe_rtt_count++;
        check_field("mode", 16'(oldest.mode), 16'(out_ch.data.mode));
        check_field("pacing_gain", oldest.pacing_gain, out_ch.data.pacing_gain);
        check_field("cwnd_gain", oldest.cwnd_gain, out_ch.data.cwnd_gain);
        check_field("force_min_cwnd", 16'(oldest.force_min_cwnd),
                    16'(out_ch.data.force_min_cwnd));
        check_field("gain_phase", 16'(oldest.gain_phase), 16'(out_ch.data.gain_phase));
      end
    end
  end

  function automatic logic [GainW-1:0] clamp_gain(input logic [GainW:0] v);
    return v[GainW] ? '1 : v[GainW-1:0];
  endfunction

  task automatic start_probe_bw(input logic [PhaseW-1:0] rp);
    cur_mode   = MODE_PROBE_BW;
    gain_phase = (rp == PHASE_LOW) ? PhaseLowStart : rp;
    pace_gain  = shadow_cfg.steady_gain;
    if (gain_phase == PHASE_HIGH)
      pace_gain = clamp_gain(17'(shadow_cfg.steady_gain) + 17'(shadow_cfg.probe_increment));
    cwnd_gain = shadow_cfg.no_pacing_mode ? pace_gain
                                          : clamp_gain({shadow_cfg.steady_gain, 1'b0});
  endtask

  task automatic advance_mode(input in_item_t ev, output out_item_t res);
    logic [TimeW:0]   end_sum;
    logic [TimeW-1:0] hold;
    logic [63:0]      bytes;
    logic [GainW-1:0] cut;
    logic             forced;
    forced = 1'b0;
    if (ev.probe_rtt_due) begin
      hold      = (ev.rtt_ns > PROBE_RTT_MIN_NS) ? ev.rtt_ns : PROBE_RTT_MIN_NS;
      end_sum   = 49'(ev.now_ns) + 49'(hold);
      rtt_end   = end_sum[TimeW] ? '1 : end_sum[TimeW-1:0];
      cur_mode  = MODE_PROBE_RTT;
      pace_gain = shadow_cfg.steady_gain;
      cwnd_gain = shadow_cfg.steady_gain;
    end
    case (cur_mode)
      MODE_STARTUP: begin
        if (ev.bw_valid) begin
          if ({24'd0, ev.bw_estimate, 8'd0} > 64'(full_bw) * 64'(shadow_cfg.growth_threshold)) begin
            full_bw   = ev.bw_estimate;
            stall_cnt = '0;
          end else begin
            if (stall_cnt < STALL_EXIT) stall_cnt++;
            if (stall_cnt >= STALL_EXIT) begin
              bytes       = (64'(ev.bdp_mbit) * 64'(DRAIN_BYTES_SCALE)) >> 16;
              cur_mode    = MODE_DRAIN;
              pace_gain   = shadow_cfg.drain_gain;
              cwnd_gain   = shadow_cfg.no_pacing_mode ? shadow_cfg.drain_gain
                                                      : shadow_cfg.start_gain;
              drain_limit = (bytes > 64'hFFFF_FFFF) ? '1 : bytes[BytesW-1:0];
              drain_cnt   = '0;
            end
          end
        end
      end
      MODE_DRAIN: begin
        drain_cnt++;
        if (ev.inflight_bytes < drain_limit || drain_cnt == DRAIN_ROUNDS_MAX)
          start_probe_bw(ev.random_phase);
      end
      MODE_PROBE_BW: begin
        cut = shadow_cfg.no_pacing_mode ? (shadow_cfg.drain_decrement >> 3)
                                        : shadow_cfg.drain_decrement;
        if (gain_phase == PHASE_HIGH)
          pace_gain = clamp_gain(17'(shadow_cfg.steady_gain) + 17'(shadow_cfg.probe_increment));
        else if (gain_phase == PHASE_LOW)
          pace_gain = (shadow_cfg.steady_gain > cut) ? shadow_cfg.steady_gain - cut : '0;
        else
          pace_gain = shadow_cfg.steady_gain;
        cwnd_gain = shadow_cfg.no_pacing_mode ? pace_gain
                                              : clamp_gain({shadow_cfg.steady_gain, 1'b0});
        gain_phase++;
      end
      default: begin
        forced = 1'b1;
        if (ev.now_ns > rtt_end) start_probe_bw(ev.random_phase);
      end
    endcase
    res.mode           = cur_mode;
    res.pacing_gain    = pace_gain;
    res.cwnd_gain      = cwnd_gain;
    res.force_min_cwnd = forced;
    res.gain_phase     = gain_phase;
  endtask

  task automatic send_round(input in_item_t ev);
    out_item_t res;
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    do @(posedge clk_i); while (!in_ch.ready);
    advance_mode(ev, res);
    pending_results.push_back(res);
    accepted_count++;
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    wait_quiet();
    write_reg(REG_STARTUP_GAIN, {16'($urandom), c.start_gain});
    write_reg(REG_DRAIN_GAIN, {16'($urandom), c.drain_gain});
    write_reg(REG_GROWTH_THRESHOLD, {16'($urandom), c.growth_threshold});
    write_reg(REG_STEADY_GAIN, {16'($urandom), c.steady_gain});
    write_reg(REG_PROBE_INCREMENT, {16'($urandom), c.probe_increment});
    write_reg(REG_DRAIN_DECREMENT, {16'($urandom), c.drain_decrement});
    write_reg(REG_NO_PACING_MODE, {31'($urandom), c.no_pacing_mode});
    write_reg(REG_MIN_CWND_BYTES, c.min_cwnd_bytes);
    cfg_we_i   <= 1'b0;
    shadow_cfg = c;
    settings_count++;
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'($urandom_range(1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_round();
    in_item_t ev;
    ev.bw_valid        = 1'($urandom_range(1));
    ev.bw_estimate     = pick_word();
    ev.bdp_mbit        = pick_word();
    ev.inflight_bytes  = pick_word();
    case ($urandom_range(19))
      0:       ev.rtt_ns = '0;
      1, 2:    ev.rtt_ns = {16'($urandom), $urandom};
      3:       ev.rtt_ns = '1;
      default: ev.rtt_ns = 48'($urandom_range(300000000));
    endcase
    case ($urandom_range(29))
      0:       wall_ns = {16'($urandom), $urandom};
      1:       wall_ns = '1 - 48'($urandom_range(1000));
      default: wall_ns = wall_ns + 48'($urandom_range(150000000));
    endcase
    ev.now_ns        = wall_ns;
    ev.probe_rtt_due = ($urandom_range(99) < 8);
    ev.random_phase  = 3'($urandom_range(7));
    return ev;
  endfunction

  function automatic in_item_t fixed_round(input logic valid, input logic [31:0] bw,
                                           input logic [31:0] bdp, input logic [47:0] rtt,
                                           input logic [47:0] now, input logic [31:0] inflight,
                                           input logic due, input logic [2:0] rp);
    in_item_t ev;
    ev.bw_valid        = valid;
    ev.bw_estimate     = bw;
    ev.bdp_mbit        = bdp;
    ev.rtt_ns          = rtt;
    ev.now_ns          = now;
    ev.inflight_bytes  = inflight;
    ev.probe_rtt_due   = due;
    ev.random_phase    = rp;
    return ev;
  endfunction

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_round(make_round());
  endtask

  task automatic test_mode_walk();
    send_round(fixed_round(1'b0, '1, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b1, 32'd1, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b1, '1, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b1, '1, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b1, '0, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b0, '0, '0, '0, '0, '0, 1'b0, 3'd0));
    send_round(fixed_round(1'b1, '1, '1, '0, '0, '0, 1'b0, 3'd0));
    for (int i = 0; i < 4; i++) send_round(fixed_round(1'b1, '1, '1, '0, '0, '1, 1'b0, 3'd7));
    send_round(fixed_round(1'b1, '1, '1, '0, '0, '1, 1'b0, PHASE_LOW));
    for (int i = 0; i < 8; i++)
      send_round(fixed_round(1'b1, '0, '0, '0, '0, '0, 1'b0, 3'($urandom_range(7))));
    send_round(fixed_round(1'b1, '0, '0, '1, 48'hFFFF_FFFF_FFFA, '0, 1'b1, 3'd0));
    send_round(fixed_round(1'b1, '0, '0, '0, 48'd1000, '0, 1'b1, 3'd0));
    send_round(fixed_round(1'b1, '0, '0, '0, 48'd200001000, '0, 1'b0, 3'd5));
    send_round(fixed_round(1'b1, '0, '0, '0, 48'd200001001, '0, 1'b0, PHASE_HIGH));
    send_round(fixed_round(1'b1, '0, '0, '0, 48'd200001002, '0, 1'b0, 3'd0));
    wall_ns = 48'd200001002;
  endtask

  task automatic test_default_settings();
    run_random(250);
  endtask

  task automatic test_saturated_settings();
    cfg_t c;
    c = '{start_gain: '1, drain_gain: '1, growth_threshold: '1, steady_gain: '1,
          probe_increment: '1, drain_decrement: '1, no_pacing_mode: 1'b1,
          min_cwnd_bytes: '1};
    load_settings(c);
    no_idle = 1'b1;
    run_random(200);
    no_idle = 1'b0;
  endtask

  task automatic test_zero_settings();
    load_settings('0);
    run_random(150);
  endtask

  task automatic test_random_settings();
    cfg_t c;
    for (int p = 0; p < 5; p++) begin
      c.start_gain       = pick_gain();
      c.drain_gain       = pick_gain();
      c.growth_threshold = pick_gain();
      c.steady_gain      = pick_gain();
      c.probe_increment  = pick_gain();
      c.drain_decrement  = pick_gain();
      c.no_pacing_mode   = 1'($urandom_range(1));
      c.min_cwnd_bytes   = pick_word();
      load_settings(c);
      run_random(100);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cycle_count   = 0;
    fail_count    = 0;
    no_idle       = 1'b0;
    wall_ns       = '0;
    shadow_cfg    = '{start_gain: STARTUP_GAIN_RST, drain_gain: DRAIN_GAIN_RST,
                      growth_threshold: GROWTH_THRESHOLD_RST, steady_gain: STEADY_GAIN_RST,
                      probe_increment: PROBE_INCREMENT_RST,
                      drain_decrement: DRAIN_DECREMENT_RST, no_pacing_mode: 1'b0,
                      min_cwnd_bytes: MIN_CWND_BYTES_RST};
    cur_mode      = MODE_STARTUP;
    full_bw       = '0;
    stall_cnt     = '0;
    drain_limit   = '0;
    drain_cnt     = '0;
    gain_phase    = '0;
    rtt_end       = '0;
    pace_gain     = STARTUP_GAIN_RST;
    cwnd_gain     = STARTUP_GAIN_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mode_walk();
    test_default_settings();
    test_saturated_settings();
    test_zero_settings();
    test_random_settings();

    wait_quiet();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d round events under %0d register loads plus reset defaults,",
             accepted_count, settings_count);
    $display("  %0d of them held in probe RTT with minimum cwnd forced.", probe_rtt_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
